[src/mmcs_pkg.sv]
// Shared types and constants for the min/max contrast stretch block.
// No dependencies; imported by every module of the block.
package mmcs_pkg;

  localparam int XW  = 33;
  localparam int NW  = 41;
  localparam int QW  = 8;
  localparam int STW = 3;
  localparam int SW  = 32;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [1:0] WID_8  = 2'd0;
  localparam logic [1:0] WID_16 = 2'd1;

  localparam logic [QW-1:0] PIX_MAX = 8'hFF;

  typedef logic signed [XW-1:0] smp_t;

  typedef struct packed {
    logic load_x;
    logic measure;
    logic prep;
    logic mul;
    logic step;
    logic load_out;
  } mmcs_cmd_t;

  typedef struct packed {
    logic trivial;
  } mmcs_stat_t;

endpackage

[src/mmcs_ctrl.sv]
// Controller state machine: sequences measure and convert transactions.
// Depends on mmcs_pkg; drives commands into mmcs_dp.
module mmcs_ctrl
  import mmcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_operation,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  mmcs_stat_t stat,
  output mmcs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          op_nxt     = in_operation;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_MEASURE) begin
          cmd.measure = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.trivial) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mul   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      op_r        <= OP_MEASURE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/mmcs_dp.sv]
// Datapath: sample decode, running min/max, range setup and radix-2 divider.
// Depends on mmcs_pkg; commanded by mmcs_ctrl.
module mmcs_dp
  import mmcs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [STW-1:0] cfg_sample_type,
  input  logic           in_first,
  input  logic [SW-1:0]  in_sample,
  input  mmcs_cmd_t      cmd,
  output mmcs_stat_t     stat,
  output logic [QW-1:0]  out_pixel
);

  logic [STW-1:0] sample_type_r, sample_type_nxt;
  smp_t           lowest_r, lowest_nxt;
  smp_t           highest_r, highest_nxt;
  smp_t           x_r, x_nxt;
  logic           first_r, first_nxt;
  logic           trivial_r, trivial_nxt;
  logic [XW-1:0]  offset_r, offset_nxt;
  logic [XW-1:0]  range_r, range_nxt;
  logic [NW-1:0]  num_r, num_nxt;
  logic [NW-1:0]  den_r, den_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [QW-1:0]  pixel_r, pixel_nxt;
  smp_t           x_dec;
  logic           is_zero;
  logic           is_sat;
  logic           fits;

  always_comb begin
    unique case (sample_type_r[2:1])
      WID_8: begin
        x_dec = sample_type_r[0] ? smp_t'($signed(in_sample[7:0]))
                                 : smp_t'({25'd0, in_sample[7:0]});
      end
      WID_16: begin
        x_dec = sample_type_r[0] ? smp_t'($signed(in_sample[15:0]))
                                 : smp_t'({17'd0, in_sample[15:0]});
      end
      default: begin
        x_dec = sample_type_r[0] ? smp_t'($signed(in_sample))
                                 : smp_t'({1'b0, in_sample});
      end
    endcase
  end

  assign is_zero = (highest_r <= lowest_r) || (x_r <= lowest_r);
  assign is_sat  = (x_r >= highest_r);
  assign fits    = (num_r >= den_r);

  always_comb begin
    sample_type_nxt = cfg_we ? cfg_sample_type : sample_type_r;
    lowest_nxt      = lowest_r;
    highest_nxt     = highest_r;
    x_nxt           = x_r;
    first_nxt       = first_r;
    trivial_nxt     = trivial_r;
    offset_nxt      = offset_r;
    range_nxt       = range_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    q_nxt           = q_r;
    pixel_nxt       = pixel_r;
    if (cmd.load_x) begin
      x_nxt     = x_dec;
      first_nxt = in_first;
    end
    if (cmd.measure) begin
      if (first_r) begin
        lowest_nxt  = x_r;
        highest_nxt = x_r;
      end else begin
        if (x_r < lowest_r) begin
          lowest_nxt = x_r;
        end
        if (x_r > highest_r) begin
          highest_nxt = x_r;
        end
      end
    end
    if (cmd.prep) begin
      trivial_nxt = is_zero || is_sat;
      q_nxt       = (!is_zero && is_sat) ? PIX_MAX : '0;
      offset_nxt  = $unsigned(x_r) - $unsigned(lowest_r);
      range_nxt   = $unsigned(highest_r) - $unsigned(lowest_r);
    end
    if (cmd.mul) begin
      num_nxt = {offset_r, 8'd0} - {8'd0, offset_r};
      den_nxt = {1'b0, range_r, 7'd0};
      q_nxt   = '0;
    end
    if (cmd.step) begin
      if (fits) begin
        num_nxt = num_r - den_r;
      end
      q_nxt   = {q_r[QW-2:0], fits};
      den_nxt = {1'b0, den_r[NW-1:1]};
    end
    if (cmd.load_out) begin
      pixel_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_type_r <= '0;
      lowest_r      <= '0;
      highest_r     <= '0;
      trivial_r     <= 1'b0;
    end else begin
      sample_type_r <= sample_type_nxt;
      lowest_r      <= lowest_nxt;
      highest_r     <= highest_nxt;
      trivial_r     <= trivial_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    first_r  <= first_nxt;
    offset_r <= offset_nxt;
    range_r  <= range_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    q_r      <= q_nxt;
    pixel_r  <= pixel_nxt;
  end

  assign stat.trivial = trivial_r;
  assign out_pixel    = pixel_r;

endmodule

[src/minmax_contrast_stretch_to_byte_top.sv]
// Top level of the min/max contrast stretch to 8-bit block.
// Depends on mmcs_pkg, mmcs_ctrl and mmcs_dp.
//
// Stream a plane twice: measure transactions (operation 0) track the running
// minimum and maximum of the samples, read per sample_type; convert
// transactions (operation 1) return floor((x-min)*255/(max-min)) as one byte,
// 0 for a flat plane or a sample at or below the minimum, 255 at or above the
// maximum. One transaction is taken at a time. A measure transaction goes
// through EXEC back to idle; a convert one goes through EXEC, MUL, the eight
// radix-2 restoring divider iterations in DIV unless clamped or flat, and
// DONE. A finished pixel waits in the output register while the next
// transaction is taken. Write sample_type only while the block is idle.
module minmax_contrast_stretch_to_byte_top
  import mmcs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [STW-1:0] cfg_sample_type,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_operation,
  input  logic           in_first,
  input  logic [SW-1:0]  in_sample,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [QW-1:0]  out_pixel
);

  mmcs_cmd_t  cmd;
  mmcs_stat_t stat;

  assign cfg_ready = 1'b1;

  mmcs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  mmcs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_sample_type (cfg_sample_type),
    .in_first        (in_first),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .stat            (stat),
    .out_pixel       (out_pixel)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a transaction without going busy");

  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("pixel loaded but no result presented");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_x, cmd.measure, cmd.prep, cmd.mul, cmd.step, cmd.load_out}))
    else $error("more than one datapath command at once");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.mul || cmd.prep) |-> in_stall)
    else $error("convert work while input is open");

endmodule
